@@ rtl/hsv2rgb_pkg.sv @@
// Constants, widths and helpers for the 12-bit HSV to RGB converter.
package hsv2rgb_pkg;

    localparam int unsigned CHAN_W    = 13;
    localparam int unsigned FRAC_BITS = 12;
    localparam int unsigned OUT_SHIFT = 24;
    localparam int unsigned POS_W     = 15;
    localparam int unsigned SV_W      = 2 * CHAN_W;
    localparam int unsigned ACC_W     = 37;

    localparam logic [CHAN_W-1:0] FULL_SCALE = CHAN_W'(4096);

    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [ACC_W-1:0]  acc_t;

    function automatic chan_t sat_full(input chan_t a);
        return (a > FULL_SCALE) ? FULL_SCALE : a;
    endfunction

endpackage

@@ rtl/hsv_to_rgb_12bit.sv @@
// Pipelined HSV to RGB converter on a 0..4096 scale.
// Throughput: one beat per cycle; a stall holds each valid stage in place,
// while an empty stage still takes the beat from the stage before it.
// Stage 1 forms sector, ramp and s*v; stage 2 the ramp product and offset;
// stage 3 the final add and channel select into the output register.
// Reset (aresetn low, synchronous) clears all stage valid bits.
module hsv_to_rgb_12bit
    import hsv2rgb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAN_W-1:0] s_hue_in,
    input  logic [CHAN_W-1:0] s_sat_in,
    input  logic [CHAN_W-1:0] s_val_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAN_W-1:0] m_red_out,
    output logic [CHAN_W-1:0] m_green_out,
    output logic [CHAN_W-1:0] m_blue_out
);

    logic              v1_reg;
    logic [2:0]        sec1_reg;
    chan_t             ramp1_reg;
    logic [SV_W-1:0]   sv1_reg;
    chan_t             val1_reg;

    logic              v2_reg;
    logic [2:0]        sec2_reg;
    acc_t              x2_reg;
    acc_t              m2_reg;
    chan_t             val2_reg;

    logic              v3_reg;
    chan_t             red3_reg;
    chan_t             green3_reg;
    chan_t             blue3_reg;

    logic              rdy1;
    logic              rdy2;
    logic              rdy3;

    chan_t             hue_sat;
    chan_t             sat_sat;
    chan_t             val_sat;
    logic [POS_W-1:0]  pos;
    logic [2:0]        sec_next;
    chan_t             frac;
    chan_t             ramp_next;
    logic [SV_W-1:0]   sv_next;

    acc_t              x_next;
    acc_t              m_next;

    acc_t              xm_sum;
    chan_t             lvl_full;
    chan_t             lvl_m;
    chan_t             lvl_xm;
    chan_t             red_next;
    chan_t             green_next;
    chan_t             blue_next;

    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_comb begin
        hue_sat   = sat_full(s_hue_in);
        sat_sat   = sat_full(s_sat_in);
        val_sat   = sat_full(s_val_in);
        pos       = POS_W'(hue_sat) * POS_W'(6);
        sec_next  = pos[POS_W-1:FRAC_BITS];
        frac      = {1'b0, pos[FRAC_BITS-1:0]};
        ramp_next = sec_next[0] ? (FULL_SCALE - frac) : frac;
        sv_next   = SV_W'(sat_sat) * SV_W'(val_sat);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_valid;
        end
        if (rdy1 && s_valid) begin
            sec1_reg  <= sec_next;
            ramp1_reg <= ramp_next;
            sv1_reg   <= sv_next;
            val1_reg  <= val_sat;
        end
    end

    always_comb begin
        x_next = ACC_W'(sv1_reg) * ACC_W'(ramp1_reg);
        m_next = (ACC_W'(val1_reg) << OUT_SHIFT) - (ACC_W'(sv1_reg) << FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
        if (rdy2 && v1_reg) begin
            sec2_reg <= sec1_reg;
            x2_reg   <= x_next;
            m2_reg   <= m_next;
            val2_reg <= val1_reg;
        end
    end

    always_comb begin
        xm_sum   = x2_reg + m2_reg;
        lvl_full = val2_reg;
        lvl_m    = m2_reg[ACC_W-1:OUT_SHIFT];
        lvl_xm   = xm_sum[ACC_W-1:OUT_SHIFT];
        case (sec2_reg)
            SECTOR_0: begin
                red_next = lvl_full; green_next = lvl_xm;   blue_next = lvl_m;
            end
            SECTOR_1: begin
                red_next = lvl_xm;   green_next = lvl_full; blue_next = lvl_m;
            end
            SECTOR_2: begin
                red_next = lvl_m;    green_next = lvl_full; blue_next = lvl_xm;
            end
            SECTOR_3: begin
                red_next = lvl_m;    green_next = lvl_xm;   blue_next = lvl_full;
            end
            SECTOR_4: begin
                red_next = lvl_xm;   green_next = lvl_m;    blue_next = lvl_full;
            end
            default: begin
                red_next = lvl_full; green_next = lvl_m;    blue_next = lvl_xm;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
        if (rdy3 && v2_reg) begin
            red3_reg   <= red_next;
            green3_reg <= green_next;
            blue3_reg  <= blue_next;
        end
    end

    assign m_valid     = v3_reg;
    assign m_red_out   = red3_reg;
    assign m_green_out = green3_reg;
    assign m_blue_out  = blue3_reg;

endmodule
